// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared sizes, status codes and control structs of the priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEAVES = 1 << SLOT_W;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_IDLE     = 3'd2,
    ST_RAN      = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // outcome of the slot search
  typedef struct packed {
    logic      has_pick;
    slot_idx_t pick_idx;
    logic      has_free;
    slot_idx_t free_idx;
  } pick_t;

  // update request into the slot table
  typedef struct packed {
    logic      arrive_en;
    logic      tick_en;
    logic      finish;
    slot_idx_t idx;
  } slot_cmd_t;

endpackage

// ===== hw/rtl/pps_select.sv =====
// ----------------------------------------------------------------------------
// pps_select
// highest priority search and lowest free slot search over the table
// ----------------------------------------------------------------------------
module pps_select (
  input  logic [pps_pkg::SLOTS-1:0]      slot_valid,
  input  logic [pps_pkg::SLOTS-1:0][7:0] slot_prio,
  output pps_pkg::pick_t                 pick
);

  localparam int NODES = 2 * pps_pkg::LEAVES - 1;

  logic                    node_valid [NODES];
  logic [7:0]              node_prio  [NODES];
  pps_pkg::slot_idx_t      node_idx   [NODES];
  logic                    free_found;
  pps_pkg::slot_idx_t      free_idx;

  // leaves, padded with empty entries up to a power of two
  for (genvar l = 0; l < pps_pkg::LEAVES; l++) begin : g_leaf
    if (l < pps_pkg::SLOTS) begin : g_real
      assign node_valid[pps_pkg::LEAVES-1+l] = slot_valid[l];
      assign node_prio[pps_pkg::LEAVES-1+l]  = slot_prio[l];
    end else begin : g_pad
      assign node_valid[pps_pkg::LEAVES-1+l] = 1'b0;
      assign node_prio[pps_pkg::LEAVES-1+l]  = 8'd0;
    end
    assign node_idx[pps_pkg::LEAVES-1+l] = pps_pkg::SLOT_W'(l);
  end

  // compare nodes: left side holds lower slots and wins ties
  for (genvar n = 0; n < pps_pkg::LEAVES - 1; n++) begin : g_node
    logic take_right;
    assign take_right = node_valid[2*n+2] &&
                        (!node_valid[2*n+1] || (node_prio[2*n+2] > node_prio[2*n+1]));
    assign node_valid[n] = node_valid[2*n+1] | node_valid[2*n+2];
    assign node_prio[n]  = take_right ? node_prio[2*n+2] : node_prio[2*n+1];
    assign node_idx[n]   = take_right ? node_idx[2*n+2]  : node_idx[2*n+1];
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pps_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = pps_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    pick.has_pick = node_valid[0];
    pick.pick_idx = node_idx[0];
    pick.has_free = free_found;
    pick.free_idx = free_idx;
  end

endmodule

// ===== hw/rtl/pps_slots.sv =====
// ----------------------------------------------------------------------------
// pps_slots
// task table: valid bits, task fields and one read port at the picked slot
// ----------------------------------------------------------------------------
module pps_slots (
  input  logic                           clk,
  input  logic                           rst,
  input  pps_pkg::slot_cmd_t             cmd,
  input  logic [7:0]                     wr_task,
  input  logic [7:0]                     wr_prio,
  input  logic [15:0]                    wr_burst,
  input  logic [31:0]                    wr_arrival,
  input  pps_pkg::slot_idx_t             rd_idx,
  output logic [pps_pkg::SLOTS-1:0]      slot_valid,
  output logic [pps_pkg::SLOTS-1:0][7:0] slot_prio,
  output logic [7:0]                     rd_task,
  output logic [15:0]                    rd_remaining,
  output logic [15:0]                    rd_burst,
  output logic [31:0]                    rd_arrival
);

  logic [7:0]  slot_task      [pps_pkg::SLOTS];
  logic [15:0] slot_remaining [pps_pkg::SLOTS];
  logic [15:0] slot_burst     [pps_pkg::SLOTS];
  logic [31:0] slot_arrival   [pps_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.arrive_en) begin
      slot_valid[cmd.idx] <= 1'b1;
    end else if (cmd.tick_en && cmd.finish) begin
      slot_valid[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arrive_en) begin
      slot_task[cmd.idx]      <= wr_task;
      slot_prio[cmd.idx]      <= wr_prio;
      slot_burst[cmd.idx]     <= wr_burst;
      slot_remaining[cmd.idx] <= wr_burst;
      slot_arrival[cmd.idx]   <= wr_arrival;
    end else if (cmd.tick_en && !cmd.finish) begin
      slot_remaining[cmd.idx] <= slot_remaining[cmd.idx] - 16'd1;
    end
  end

  assign rd_task      = slot_task[rd_idx];
  assign rd_remaining = slot_remaining[rd_idx];
  assign rd_burst     = slot_burst[rd_idx];
  assign rd_arrival   = slot_arrival[rd_idx];

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// task table with highest priority selection, one time unit per tick item
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a rising edge with start high and busy low; busy
//   stays low, so an item may be given in every cycle
//   op selects arrive (task_id, task_priority, burst_length are stored in
//   the lowest free slot, stamped with the time counter) or tick (the valid
//   task with the highest priority runs one unit, ties to the lowest slot)
//   every item gives exactly one result, shown for one cycle with done high
// pipeline:
//   item captured in an input register at the accepting edge, worked in the
//   next cycle by the search tree and table update, result and done registered
//   at the end of that cycle
//   one item per cycle, as busy stays low; the select and update path is
//   combinational between the input and result registers
// reset:
//   rst (synchronous) empties the table, zeroes the time counter and drops
//   any item in flight; the receiver cannot stall, results are never held
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  task_id,
  input  logic [7:0]  task_priority,
  input  logic [15:0] burst_length,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  ran_id,
  output logic [31:0] finish_time,
  output logic [31:0] turnaround,
  output logic [31:0] waiting
);

  // input register
  logic        in_valid;
  logic        in_op;
  logic [7:0]  in_id;
  logic [7:0]  in_prio;
  logic [15:0] in_burst;

  // time counter
  logic [31:0] current_time;
  logic [31:0] current_time_next;
  logic [31:0] time_inc;

  // table interface
  logic [pps_pkg::SLOTS-1:0]      slot_valid;
  logic [pps_pkg::SLOTS-1:0][7:0] slot_prio;
  pps_pkg::pick_t                 pick;
  pps_pkg::slot_cmd_t             cmd;
  logic [7:0]                     rd_task;
  logic [15:0]                    rd_remaining;
  logic [15:0]                    rd_burst;
  logic [31:0]                    rd_arrival;

  // result values before the output register
  pps_pkg::status_t status_next;
  logic [7:0]       ran_id_next;
  logic [31:0]      finish_time_next;
  logic [31:0]      turnaround_next;
  logic [31:0]      waiting_next;
  logic             finishing;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op    <= op;
      in_id    <= task_id;
      in_prio  <= task_priority;
      in_burst <= burst_length;
    end
  end

  pps_select u_select (
    .slot_valid (slot_valid),
    .slot_prio  (slot_prio),
    .pick       (pick)
  );

  pps_slots u_slots (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .wr_task      (in_id),
    .wr_prio      (in_prio),
    .wr_burst     (in_burst),
    .wr_arrival   (current_time),
    .rd_idx       (pick.pick_idx),
    .slot_valid   (slot_valid),
    .slot_prio    (slot_prio),
    .rd_task      (rd_task),
    .rd_remaining (rd_remaining),
    .rd_burst     (rd_burst),
    .rd_arrival   (rd_arrival)
  );

  assign time_inc  = current_time + 32'd1;
  // a burst of zero or one left ends on this tick
  assign finishing = (rd_remaining <= 16'd1);

  always_comb begin
    current_time_next = current_time;
    cmd               = '0;
    status_next       = pps_pkg::ST_ACCEPTED;
    ran_id_next       = 8'd0;
    finish_time_next  = 32'd0;
    turnaround_next   = 32'd0;
    waiting_next      = 32'd0;

    if (in_valid) begin
      if (in_op == pps_pkg::OP_ARRIVE) begin
        // arrival: lowest free slot, refused when the table is full
        if (pick.has_free) begin
          cmd.arrive_en = 1'b1;
          cmd.idx       = pick.free_idx;
          status_next   = pps_pkg::ST_ACCEPTED;
        end else begin
          status_next   = pps_pkg::ST_FULL;
        end
      end else begin
        // tick: time moves on even with an empty table
        current_time_next = time_inc;
        if (!pick.has_pick) begin
          status_next = pps_pkg::ST_IDLE;
        end else begin
          cmd.tick_en = 1'b1;
          cmd.finish  = finishing;
          cmd.idx     = pick.pick_idx;
          ran_id_next = rd_task;
          if (finishing) begin
            status_next      = pps_pkg::ST_FINISHED;
            finish_time_next = time_inc;
            turnaround_next  = time_inc - rd_arrival;
            waiting_next     = time_inc - rd_arrival - {16'd0, rd_burst};
          end else begin
            status_next = pps_pkg::ST_RAN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= 32'd0;
      done         <= 1'b0;
    end else begin
      current_time <= current_time_next;
      done         <= in_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    status      <= status_next;
    ran_id      <= ran_id_next;
    finish_time <= finish_time_next;
    turnaround  <= turnaround_next;
    waiting     <= waiting_next;
  end

endmodule

// ===== tb/sv/preemptive_priority_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// self-checking bench for the task table and highest priority tick scheduler
// ----------------------------------------------------------------------------
// items go in over the start/busy handshake. Each accepted item is run
// through an in-bench copy of the task table, which queues the one outcome
// it should give. Every done strobe is compared field by field with the
// oldest queued outcome. A short directed run covers the field extremes,
// the empty table, a zero burst, priority ties and a full table. Random
// traffic then swings between filling and draining the table, under three
// sender idle profiles.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with neither an accepted item nor a result before the run gives up
  localparam int STALL_LIMIT = 1000;
  // cap on tasks given a full range burst, which may hold a slot for the whole run
  localparam int LONG_TASK_CAP = 4;

  // one expected result of the block
  typedef struct {
    pps_pkg::status_t status;
    logic [7:0]       ran_id;
    logic [31:0]      finish_time;
    logic [31:0]      turnaround;
    logic [31:0]      waiting;
  } outcome_t;

  // --------------------------------------------------------------------------
  // task table tracker: own copy of the slots and the time counter, plus the
  // outcomes still owed by the block, oldest first
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    bit          slot_used [pps_pkg::SLOTS];
    logic [7:0]  slot_id   [pps_pkg::SLOTS];
    logic [7:0]  slot_prio [pps_pkg::SLOTS];
    logic [15:0] slot_left [pps_pkg::SLOTS];
    logic [15:0] slot_burst[pps_pkg::SLOTS];
    logic [31:0] slot_stamp[pps_pkg::SLOTS];
    logic [31:0] clock_now;
    outcome_t    owed_outcomes[$];
    int          errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      clock_now = '0;
      errors    = 0;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i]) n++;
      return n;
    endfunction

    function int owed();
      return owed_outcomes.size();
    endfunction

    // works out the outcome of one accepted item and updates the table
    function void take_item(pps_pkg::op_t kind, logic [7:0] id, logic [7:0] prio,
                            logic [15:0] burst);
      outcome_t o;
      int       pick;
      o.status      = pps_pkg::ST_ACCEPTED;
      o.ran_id      = '0;
      o.finish_time = '0;
      o.turnaround  = '0;
      o.waiting     = '0;
      pick = -1;
      if (kind == pps_pkg::OP_ARRIVE) begin
        // lowest free slot takes the task
        for (int i = 0; i < pps_pkg::SLOTS; i++) begin
          if (!slot_used[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          o.status = pps_pkg::ST_FULL;
        end else begin
          slot_used[pick]  = 1'b1;
          slot_id[pick]    = id;
          slot_prio[pick]  = prio;
          slot_burst[pick] = burst;
          slot_left[pick]  = burst;
          slot_stamp[pick] = clock_now;
        end
      end else begin
        // strict greater keeps ties on the lowest slot
        for (int i = 0; i < pps_pkg::SLOTS; i++) begin
          if (slot_used[i] && (pick < 0 || slot_prio[i] > slot_prio[pick])) pick = i;
        end
        clock_now = clock_now + 32'd1;
        if (pick < 0) begin
          o.status = pps_pkg::ST_IDLE;
        end else if (slot_left[pick] <= 16'd1) begin
          // a zero burst also ends here, on its first run
          o.status        = pps_pkg::ST_FINISHED;
          o.ran_id        = slot_id[pick];
          o.finish_time   = clock_now;
          o.turnaround    = clock_now - slot_stamp[pick];
          o.waiting       = o.turnaround - {16'h0000, slot_burst[pick]};
          slot_left[pick] = '0;
          slot_used[pick] = 1'b0;
        end else begin
          o.status        = pps_pkg::ST_RAN;
          o.ran_id        = slot_id[pick];
          slot_left[pick] = slot_left[pick] - 16'd1;
        end
      end
      owed_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // matches one strobed result against the oldest owed outcome
    function void check_outcome(logic [2:0] st, logic [7:0] id, logic [31:0] fin,
                                logic [31:0] tat, logic [31:0] wt);
      outcome_t o;
      if (owed_outcomes.size() == 0) begin
        $error("result with no item waiting: status %0d, ran_id %0d", st, id);
        errors++;
        return;
      end
      o = owed_outcomes.pop_front();
      compare_field("status", 32'(o.status), 32'(st));
      compare_field("ran_id", 32'(o.ran_id), 32'(id));
      compare_field("finish_time", o.finish_time, fin);
      compare_field("turnaround", o.turnaround, tat);
      compare_field("waiting", o.waiting, wt);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block pins; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic        busy;
  logic        op            = pps_pkg::OP_ARRIVE;
  logic [7:0]  task_id       = '0;
  logic [7:0]  task_priority = '0;
  logic [15:0] burst_length  = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  ran_id;
  logic [31:0] finish_time;
  logic [31:0] turnaround;
  logic [31:0] waiting;

  sched_scoreboard board = new();
  int              stall_cycles = 0;
  int              long_tasks   = 0;

  always #4 clk = ~clk;

  preemptive_priority_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .task_id      (task_id),
    .task_priority(task_priority),
    .burst_length (burst_length),
    .done         (done),
    .status       (status),
    .ran_id       (ran_id),
    .finish_time  (finish_time),
    .turnaround   (turnaround),
    .waiting      (waiting)
  );

  // results are sampled at the edge that ends their one cycle of done
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_outcome(status, ran_id, finish_time, turnaround, waiting);
    end
  end

  // watchdog: gives up when neither side moves for too long
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && done)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[preemptive_priority_scheduler] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // driver: optional idle gap, then hold the item until the block takes it.
  // start stays high on return so back to back items need no extra edge
  // --------------------------------------------------------------------------
  task automatic send_item(pps_pkg::op_t kind, logic [7:0] id, logic [7:0] prio,
                           logic [15:0] burst, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    op            <= kind;
    task_id       <= id;
    task_priority <= prio;
    burst_length  <= burst;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_item(kind, id, prio, burst);
  endtask

  // random traffic: alternating fill and drain stretches so the table keeps
  // going from empty to full and back
  task automatic run_random(int count, int idle_pct);
    pps_pkg::op_t kind;
    logic [7:0]   id;
    logic [7:0]   prio;
    logic [15:0]  burst;
    int           arrive_pct;
    for (int n = 0; n < count; n++) begin
      arrive_pct = ((n / 30) % 2 == 0) ? 70 : 20;
      kind  = ($urandom_range(99) < arrive_pct) ? pps_pkg::OP_ARRIVE : pps_pkg::OP_TICK;
      // fields of ticks and of refused arrivals are don't care: full range
      id    = 8'($urandom_range(255));
      prio  = 8'($urandom_range(255));
      burst = 16'($urandom_range(65535));
      if (kind == pps_pkg::OP_ARRIVE && board.used_slots() < pps_pkg::SLOTS) begin
        // narrow priorities make ties common
        if ($urandom_range(1) == 0) prio = 8'($urandom_range(3));
        if ($urandom_range(19) == 0) begin
          burst = '0;
        end else if (long_tasks < LONG_TASK_CAP && $urandom_range(59) == 0) begin
          long_tasks++;
        end else begin
          burst = 16'($urandom_range(6, 1));
        end
      end
      send_item(kind, id, prio, burst, idle_pct);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // tick on an empty table only advances time
    send_item(pps_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 23);
    // zero burst finishes on its first run, lowest id and priority
    send_item(pps_pkg::OP_ARRIVE, 8'h00, 8'h00, 16'h0000, 23);
    send_item(pps_pkg::OP_TICK, 8'hff, 8'hff, 16'hffff, 23);
    // two tasks at top priority: the lower slot goes first
    send_item(pps_pkg::OP_ARRIVE, 8'hff, 8'hff, 16'h0001, 23);
    send_item(pps_pkg::OP_ARRIVE, 8'ha5, 8'hff, 16'h0002, 23);
    send_item(pps_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 23);
    send_item(pps_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 23);
    send_item(pps_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 23);
    // longest burst at the lowest priority, it keeps a slot for the run
    send_item(pps_pkg::OP_ARRIVE, 8'h3c, 8'h00, 16'hffff, 23);
    long_tasks++;
    // fill the rest of the table, then knock on it once more
    for (int i = 1; i < pps_pkg::SLOTS; i++) begin
      send_item(pps_pkg::OP_ARRIVE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(3, 1)), 23);
    end
    send_item(pps_pkg::OP_ARRIVE, 8'hff, 8'hff, 16'hffff, 23);

    // random part under each sender idle profile
    run_random(242, 23);
    run_random(242, 75);
    run_random(242, 0);
    start <= 1'b0;

    // drain the owed results, then keep the clock running to catch stray strobes
    while (board.owed() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("[preemptive_priority_scheduler] OK");
    end else begin
      $display("[preemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pps_pkg.sv
hw/rtl/pps_select.sv
hw/rtl/pps_slots.sv
hw/rtl/preemptive_priority_scheduler.sv
tb/sv/preemptive_priority_scheduler_tb.sv
